// File: src/rpn_pkg.sv
package rpn_pkg;
	localparam int STACK_DEPTH = 64;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int DW = 32;

	localparam logic [2:0] KIND_NUM = 3'd0;
	localparam logic [2:0] KIND_ADD = 3'd1;
	localparam logic [2:0] KIND_SUB = 3'd2;
	localparam logic [2:0] KIND_MUL = 3'd3;
	localparam logic [2:0] KIND_DIV = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;
	localparam logic [1:0] ST_DIV0  = 2'd3;

	typedef struct packed {
		logic [2:0]  kind;
		logic signed [31:0] operand;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic signed [31:0] top_value;
		logic [6:0]  depth;
		logic [1:0]  status;
		logic        final_res;
	} res_t;
endpackage

// File: src/rpn_if.sv
interface rpn_tok_if;
	import rpn_pkg::*;
	logic valid;
	logic ready;
	tok_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rpn_res_if;
	import rpn_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/rpn_ram.sv
module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: src/rpn_div.sv
module rpn_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quot
);
	import rpn_pkg::*;

	logic [31:0] q_q, d_q;
	logic [32:0] r_q;
	logic [5:0]  cnt_q;
	logic        busy_q, neg_q;
	logic [32:0] r_sh, r_sub;

	assign r_sh  = {r_q[31:0], q_q[31]};
	assign r_sub = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// one quotient bit a cycle on magnitudes
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num[31] ? 32'(-num) : num;
			d_q   <= den[31] ? 32'(-den) : den;
			r_q   <= '0;
			neg_q <= num[31] ^ den[31];
		end else if (busy_q) begin
			if (!r_sub[32]) begin
				r_q <= r_sub;
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign quot = neg_q ? 32'(-q_q) : q_q;
endmodule

// File: src/rpn_stack_evaluator_core.sv
// channel | dir | payload
// tok     | in  | kind, operand, last
// res     | out | top_value, depth, status, final_res
// Number, unused kinds, underflow, overflow: IDLE, TOP, OUT, then the result register.
// Add, sub, mul, divide by zero: IDLE, RDB, RDA, EXE, TOP, OUT, then the result register.
// Divide: as add, with DIV between EXE and TOP, waiting on the 32-step one-bit divider.
// Reset clears the count and the FSM; the RAM holds no reset.
// The next item is taken while a result waits; hold in the output state until it leaves.
module rpn_stack_evaluator_core (
	input logic clk,
	input logic arst_n,
	rpn_tok_if.sink tok,
	rpn_res_if.source res
);
	import rpn_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0, S_RDB = 3'd1, S_RDA = 3'd2, S_EXE = 3'd3,
		S_DIV = 3'd4, S_TOP = 3'd5, S_OUT = 3'd6;

	logic [2:0]    st_q;
	logic [CW-1:0] cnt_q;
	tok_t          tk_q;
	logic [31:0]   b_q, a_q;
	logic [1:0]    stat_q;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata, rdata, quot;
	logic          div_start, div_done;
	logic [31:0]   mul_r;

	rpn_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	rpn_div u_div (
		.clk, .arst_n, .start(div_start), .num(a_q), .den(b_q),
		.done(div_done), .quot
	);

	assign tok.ready = (st_q == S_IDLE);
	assign mul_r = 32'(a_q * b_q);
	assign div_start = (st_q == S_EXE) && (tk_q.kind == KIND_DIV) && (b_q != '0);

	always_comb begin
		raddr = AW'(cnt_q - CW'(1));
		if (st_q == S_RDB) raddr = AW'(cnt_q - CW'(2));
		we = 1'b0;
		waddr = AW'(cnt_q - CW'(2));
		wdata = '0;
		if (tok.valid && tok.ready && tok.data.kind == KIND_NUM
			&& cnt_q != CW'(STACK_DEPTH)) begin
			we = 1'b1; waddr = AW'(cnt_q); wdata = tok.data.operand;
		end else if (st_q == S_EXE && tk_q.kind != KIND_DIV) begin
			we = 1'b1;
			case (tk_q.kind)
				KIND_ADD: wdata = a_q + b_q;
				KIND_SUB: wdata = a_q - b_q;
				default:  wdata = mul_r;
			endcase
		end else if (st_q == S_DIV && div_done) begin
			we = 1'b1; wdata = quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			res.valid <= 1'b0;
		end else begin
			if (st_q == S_OUT && (!res.valid || res.ready)) res.valid <= 1'b1;
			else if (res.ready) res.valid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (tok.valid && tok.ready) begin
					tk_q <= tok.data;
					stat_q <= ST_OK;
					if (tok.data.kind == KIND_NUM) begin
						if (cnt_q == CW'(STACK_DEPTH)) stat_q <= ST_OVER;
						else cnt_q <= cnt_q + CW'(1);
						st_q <= S_TOP;
					end else if (tok.data.kind > KIND_DIV) begin
						st_q <= S_TOP;
					end else if (cnt_q < CW'(2)) begin
						stat_q <= ST_UNDER;
						st_q <= S_TOP;
					end else st_q <= S_RDB;
				end
				// top entry was read at the accepting edge, the deeper one in RDB
				S_RDB: begin b_q <= rdata; st_q <= S_RDA; end
				S_RDA: begin a_q <= rdata; st_q <= S_EXE; end
				S_EXE: begin
					if (tk_q.kind == KIND_DIV) begin
						if (b_q == '0) begin stat_q <= ST_DIV0; st_q <= S_TOP; end
						else st_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q - CW'(1);
						st_q <= S_TOP;
					end
				end
				S_DIV: if (div_done) begin
					cnt_q <= cnt_q - CW'(1);
					st_q <= S_TOP;
				end
				S_TOP: st_q <= S_OUT;
				S_OUT: if (!res.valid || res.ready) begin
					res.data.top_value <= (cnt_q == '0) ? '0 : rdata;
					res.data.depth <= 7'(cnt_q);
					res.data.status <= stat_q;
					res.data.final_res <= tk_q.last;
					if (tk_q.last) cnt_q <= '0;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH)) else $error("count beyond depth");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != S_IDLE |-> !tok.ready) else $error("ready while busy");
	a_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_OUT |=> res.valid) else $error("result not raised");
`endif
endmodule

// File: tb/rpn_checker.sv
`timescale 1ns / 1ps
module rpn_checker
	import rpn_pkg::*;
(
	input logic clk,
	input logic arst_n,
	rpn_tok_if.sink tok,
	rpn_res_if.sink res,
	output int fail_count,
	output int pending,
	output int result_count
);
	logic [31:0] stack_mem [STACK_DEPTH];
	int stack_cnt;
	res_t expected_q[$];

	function automatic logic [31:0] div_toward_zero(logic [31:0] a, logic [31:0] b);
		logic [31:0] am, bm, q;
		am = a[31] ? -a : a;
		bm = b[31] ? -b : b;
		q = am / bm;
		if (a[31] != b[31])
			q = -q;
		return q;
	endfunction

	task automatic eval_token(tok_t t);
		res_t r;
		logic [31:0] x, y, v;
		logic [1:0] st;
		st = ST_OK;
		v = '0;
		if (t.kind == KIND_NUM) begin
			if (stack_cnt >= STACK_DEPTH)
				st = ST_OVER;
			else begin
				stack_mem[stack_cnt] = t.operand;
				stack_cnt++;
			end
		end else if (t.kind <= KIND_DIV) begin
			if (stack_cnt < 2)
				st = ST_UNDER;
			else begin
				y = stack_mem[stack_cnt - 1];
				x = stack_mem[stack_cnt - 2];
				case (t.kind)
					KIND_ADD: v = x + y;
					KIND_SUB: v = x - y;
					KIND_MUL: v = x * y;
					default: begin
						if (y == 0)
							st = ST_DIV0;
						else
							v = div_toward_zero(x, y);
					end
				endcase
				if (st == ST_OK) begin
					stack_cnt--;
					stack_mem[stack_cnt - 1] = v;
				end
			end
		end
		r.top_value = (stack_cnt != 0) ? stack_mem[stack_cnt - 1] : '0;
		r.depth = 7'(stack_cnt);
		r.status = st;
		r.final_res = t.last;
		expected_q.push_back(r);
		if (t.last)
			stack_cnt = 0;
	endtask

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			stack_cnt = 0;
			fail_count = 0;
			result_count = 0;
			expected_q.delete();
		end else begin
			if (res.valid && res.ready) begin
				result_count++;
				if (expected_q.size() == 0) begin
					$error("result with nothing expected");
					fail_count++;
				end else begin
					e = expected_q.pop_front();
					if (res.data.top_value !== e.top_value) begin
						$error("top_value expected %0d actual %0d", e.top_value,
							res.data.top_value);
						fail_count++;
					end
					if (res.data.depth !== e.depth) begin
						$error("depth expected %0d actual %0d", e.depth, res.data.depth);
						fail_count++;
					end
					if (res.data.status !== e.status) begin
						$error("status expected %0d actual %0d", e.status, res.data.status);
						fail_count++;
					end
					if (res.data.final_res !== e.final_res) begin
						$error("final_res expected %0d actual %0d", e.final_res,
							res.data.final_res);
						fail_count++;
					end
				end
			end
			if (tok.valid && tok.ready)
				eval_token(tok.data);
		end
	end
endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import rpn_pkg::*;
	logic clk;
	logic arst_n;
	int fail_count, pending, result_count;
	int sent;
	int cycle_count;
	int depth_model;
	bit res_stall_on;

	rpn_tok_if tok ();
	rpn_res_if res ();

	rpn_stack_evaluator_core dut (.clk(clk), .arst_n(arst_n), .tok(tok), .res(res));
	rpn_checker chk (.clk(clk), .arst_n(arst_n), .tok(tok), .res(res),
		.fail_count(fail_count), .pending(pending), .result_count(result_count));

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 2000000) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 60);
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 3);
	endfunction

	// Sink side: random stall stretches, with quiet phases of no stalling.
	initial begin
		res.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) == 0)
				res_stall_on = ~res_stall_on;
			if (res_stall_on && $urandom_range(0, 2) == 0)
				res.ready <= 0;
			else if (res_stall_on && $urandom_range(0, 40) == 0) begin
				res.ready <= 0;
				repeat (gap_len()) @(posedge clk);
				res.ready <= 1;
			end else
				res.ready <= 1;
		end
	end

	task automatic send_token(logic [2:0] k, logic [31:0] v, logic l);
		int g;
		g = gap_len();
		if (g > 0) begin
			tok.valid <= 0;
			repeat (g) @(posedge clk);
		end
		tok.valid <= 1;
		tok.data <= '{kind: k, operand: v, last: l};
		@(posedge clk);
		while (!tok.ready) @(posedge clk);
		sent++;
		if (k == KIND_NUM && depth_model < STACK_DEPTH)
			depth_model++;
		else if (k >= KIND_ADD && k <= KIND_DIV && depth_model >= 2)
			depth_model--;
		if (l)
			depth_model = 0;
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return $urandom_range(0, 9);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [2:0] k;
		int n;
		sent = 0;
		depth_model = 0;
		res_stall_on = 0;
		arst_n = 0;
		tok.valid = 0;
		tok.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: underflow, extremes, each operator, div by zero, min / -1, unused kinds.
		send_token(KIND_ADD, 0, 0);
		send_token(KIND_NUM, 32'h8000_0000, 0);
		send_token(KIND_NUM, 32'hffff_ffff, 0);
		send_token(KIND_DIV, 0, 0);
		send_token(KIND_NUM, 32'h7fff_ffff, 0);
		send_token(KIND_ADD, 0, 0);
		send_token(KIND_NUM, 32'h7fff_ffff, 0);
		send_token(KIND_MUL, 0, 0);
		send_token(KIND_NUM, 0, 0);
		send_token(KIND_DIV, 0, 0);
		send_token(KIND_NUM, 32'hffff_fff9, 0);
		send_token(KIND_SUB, 0, 0);
		send_token(KIND_NUM, 2, 0);
		send_token(KIND_DIV, 32'hffff_ffff, 0);
		send_token(3'd5, 32'h1234, 0);
		send_token(3'd6, 0, 0);
		send_token(3'd7, 32'hffff_ffff, 1);
		send_token(KIND_SUB, 0, 1);
		// Fill to overflow and report it on a last item.
		for (int i = 0; i < STACK_DEPTH; i++)
			send_token(KIND_NUM, rand_value(), 0);
		send_token(KIND_NUM, 5, 1);
		while (sent < 1450) begin
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) == 0)
					k = 3'($urandom_range(0, 7));
				else if (depth_model < 2 || $urandom_range(0, 1) == 0)
					k = KIND_NUM;
				else
					k = 3'($urandom_range(KIND_ADD, KIND_DIV));
				send_token(k, rand_value(), i == n - 1);
			end
			if ($urandom_range(0, 60) == 0) begin
				for (int i = 0; i < STACK_DEPTH + 2; i++)
					send_token(KIND_NUM, $urandom, 0);
				send_token(KIND_ADD, 0, 1);
			end
		end
		tok.valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d tokens, checked %0d results: all kinds, errors, full stack.",
			sent, result_count);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
